// ----- rtl/bfa_pkg.sv -----
// Shared definitions for the bitmap frame allocator.
// Holds request codes, status codes and default sizes. No dependencies.
package bfa_pkg;

	localparam int BFA_MAP_WORDS     = 1024;
	localparam int BFA_BITS_PER_WORD = 32;
	localparam int BFA_FRAME_BYTES   = 4096;

	localparam int BFA_IN_DATA_W  = 48;
	localparam int BFA_OUT_DATA_W = 48;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_QUERY   = 2'd2;
	localparam logic [1:0] REQ_RESERVE = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OOM      = 3'd1;
	localparam logic [2:0] ST_ZERO     = 3'd2;
	localparam logic [2:0] ST_MISALIGN = 3'd3;
	localparam logic [2:0] ST_NOTALLOC = 3'd4;
	localparam logic [2:0] ST_RANGE    = 3'd5;

endpackage

// ----- rtl/bfa_ram.sv -----
// Free map storage: one write port, one read port, registered read data.
// Depends on bfa_pkg.
module bfa_ram
	import bfa_pkg::*;
#(
	parameter int DEPTH = BFA_MAP_WORDS,
	parameter int WIDTH = BFA_BITS_PER_WORD,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/bitmap_frame_allocator.sv -----
// First-fit bitmap frame allocator, top level.
// Depends on bfa_pkg and bfa_ram.
//
// The block keeps a free map (one bit per frame, 1 = free) in a single synchronous RAM of
// MAP_WORDS words and serves one request at a time: allocate, free, query or reserve. Each
// request gives exactly one result. The work runs through the single RAM port pair and the
// bit-serial run scanner: allocate scans bit by bit from the hint word, then clears the run
// word by word, then moves the hint past words with no free frame; free tests and sets one
// frame at a time and zero-fills a new word each time the map grows; query and reserve each
// touch a single word. A finished result sits in an output register, so the next request
// is taken while it waits. No clearing pass runs after reset: words beyond the in-use
// count are never used, and the map is zero-filled word by word as frees grow it.
// FRAME_BYTES and BITS_PER_WORD must be powers of two.
module bitmap_frame_allocator
	import bfa_pkg::*;
#(
	parameter int MAP_WORDS     = BFA_MAP_WORDS,
	parameter int BITS_PER_WORD = BFA_BITS_PER_WORD,
	parameter int FRAME_BYTES   = BFA_FRAME_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// frame_address[31:0], frame_count[47:32]
	input  logic [BFA_IN_DATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[2:0], base_address[34:3], frame_is_allocated[35],
	// map_words_in_use[46:36], zero[47]
	output logic [BFA_OUT_DATA_W-1:0] m_tdata
);

	localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HW  = AW + 1;                  // hint and in-use count
	localparam int BSH = $clog2(BITS_PER_WORD);   // bit index width
	localparam int FSH = $clog2(FRAME_BYTES);
	localparam int FW  = 33 - FSH;                // frame number, room for count overrun
	localparam int SW  = AW + BSH;                // frame number inside the map
	localparam int WW  = FW - BSH;                // word number of a frame

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_AL_RD  = 5'd1;
	localparam logic [4:0] S_AL_BIT = 5'd2;
	localparam logic [4:0] S_CL_RD  = 5'd3;
	localparam logic [4:0] S_CL_WR  = 5'd4;
	localparam logic [4:0] S_SK_CHK = 5'd5;
	localparam logic [4:0] S_SK_TST = 5'd6;
	localparam logic [4:0] S_FR_CHK = 5'd7;
	localparam logic [4:0] S_FR_TST = 5'd8;
	localparam logic [4:0] S_Q_TST  = 5'd9;
	localparam logic [4:0] S_RS_WR  = 5'd10;
	localparam logic [4:0] S_FIN    = 5'd11;

	logic [4:0]  state_q;
	logic [15:0] count_q;      // allocate size, then frames left to free or clear
	logic [FW-1:0] frame_q;    // current frame for free, query, reserve, clear
	logic [HW-1:0] wiu_q;
	logic [HW-1:0] hint_q;
	logic [AW-1:0] word_q;     // word under allocate scan
	logic [BSH-1:0] bit_q;
	logic [15:0] run_q;
	logic [SW-1:0] start_q;
	logic        wrap_q;
	logic [2:0]  status_q;
	logic        alloc_q;
	logic        out_valid_q;
	logic [BFA_OUT_DATA_W-1:0] out_data_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [BITS_PER_WORD-1:0] ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [BITS_PER_WORD-1:0] ram_rdata;

	// Decode of the request at the input and of the current frame.
	logic [FW-1:0]  in_frame;
	logic [WW-1:0]  in_word;
	logic [WW-1:0]  cur_word;
	logic [BSH-1:0] cur_bit;
	logic [BITS_PER_WORD-1:0] cur_onehot;
	logic [BITS_PER_WORD-1:0] clr_mask;
	logic [BSH:0]   clr_take;
	logic [16:0]    run_next;
	logic           scan_bit;
	logic [2:0]     acc_status;
	logic           acc_alloc;
	logic [4:0]     acc_state;

	assign in_frame   = FW'(s_tdata[31:FSH]);
	assign in_word    = in_frame[FW-1:BSH];
	assign cur_word   = frame_q[FW-1:BSH];
	assign cur_bit    = frame_q[BSH-1:0];
	assign cur_onehot = BITS_PER_WORD'(1) << cur_bit;
	assign scan_bit   = ram_rdata[bit_q];
	assign run_next   = scan_bit ? 17'(run_q) + 17'd1 : 17'd0;

	// Early answer and next state for the request at the input.
	always_comb begin
		acc_status = ST_OK;
		acc_alloc  = 1'b0;
		acc_state  = S_FIN;
		case (s_tuser)
			REQ_ALLOC: begin
				if (s_tdata[47:32] == '0) begin
					acc_status = ST_ZERO;
				end else if (hint_q >= wiu_q) begin
					acc_status = ST_OOM;
				end else begin
					acc_state = S_AL_RD;
				end
			end
			REQ_FREE: begin
				if (s_tdata[FSH-1:0] != '0) begin
					acc_status = ST_MISALIGN;
				end else begin
					acc_state = S_FR_CHK;
				end
			end
			REQ_QUERY: begin
				if (32'(in_word) >= 32'(MAP_WORDS)) begin
					acc_status = ST_RANGE;
					acc_alloc  = 1'b1;
				end else if (HW'(in_word) >= wiu_q) begin
					acc_alloc = 1'b1;
				end else begin
					acc_state = S_Q_TST;
				end
			end
			default: begin
				if (32'(in_word) >= 32'(MAP_WORDS)) begin
					acc_status = ST_RANGE;
				end else if (HW'(in_word) < wiu_q) begin
					acc_state = S_RS_WR;
				end
			end
		endcase
	end

	// Bits of the run that fall in the current word: from cur_bit for up to count_q frames.
	always_comb begin
		logic [BSH:0] room;
		room = (BSH+1)'(BITS_PER_WORD) - (BSH+1)'(cur_bit);
		clr_take = (17'(count_q) >= 17'(room)) ? room : (BSH+1)'(count_q);
		for (int b = 0; b < BITS_PER_WORD; b++) begin
			clr_mask[b] = ((BSH+1)'(b) >= (BSH+1)'(cur_bit))
				&& (((BSH+1)'(b) - (BSH+1)'(cur_bit)) < clr_take);
		end
	end

	// RAM port control: reads issue in the state before the data is used; a read never
	// issues in the same cycle as a write.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_word[AW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = cur_word[AW-1:0];
		case (state_q)
			S_IDLE: begin
				ram_re    = s_tvalid;
				ram_raddr = in_word[AW-1:0];
			end
			S_AL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = word_q;
			end
			S_CL_RD: begin
				ram_re = 1'b1;
			end
			S_CL_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~clr_mask;
			end
			S_SK_CHK: begin
				ram_re    = 1'b1;
				ram_raddr = hint_q[AW-1:0];
			end
			S_FR_CHK: begin
				if (count_q != '0 && 32'(cur_word) < 32'(MAP_WORDS)) begin
					if (HW'(cur_word) >= wiu_q) begin
						// grow the map: zero-fill the next word
						ram_we    = 1'b1;
						ram_waddr = wiu_q[AW-1:0];
						ram_wdata = '0;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			S_FR_TST: begin
				ram_we    = !(|(ram_rdata & cur_onehot));
				ram_wdata = ram_rdata | cur_onehot;
			end
			S_RS_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata & ~cur_onehot;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wiu_q       <= '0;
			hint_q      <= '1;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is loaded this cycle
			if (out_valid_q && m_tready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						count_q  <= s_tdata[47:32];
						frame_q  <= in_frame;
						status_q <= acc_status;
						alloc_q  <= acc_alloc;
						start_q  <= '0;
						state_q  <= acc_state;
						word_q   <= hint_q[AW-1:0];
						run_q    <= '0;
						wrap_q   <= 1'b0;
					end
				end
				S_AL_RD: begin
					bit_q   <= '0;
					state_q <= S_AL_BIT;
				end
				S_AL_BIT: begin
					// walk the word one bit a cycle, carrying the run across words
					run_q <= run_next[15:0];
					if (scan_bit && run_q == '0) begin
						start_q <= {word_q, bit_q};
					end
					if (run_next >= 17'(count_q)) begin
						frame_q <= (run_q == '0) ? FW'({word_q, bit_q}) : FW'(start_q);
						state_q <= S_CL_RD;
					end else if (bit_q == BSH'(BITS_PER_WORD - 1)) begin
						if (HW'(word_q) + HW'(1) >= wiu_q) begin
							status_q <= ST_OOM;
							state_q  <= S_FIN;
						end else begin
							word_q  <= word_q + AW'(1);
							state_q <= S_AL_RD;
						end
					end else begin
						bit_q <= bit_q + BSH'(1);
					end
				end
				S_CL_RD: begin
					state_q <= S_CL_WR;
				end
				S_CL_WR: begin
					// clear this word's part of the run, advance to the next word
					frame_q <= frame_q + FW'(clr_take);
					count_q <= count_q - 16'(clr_take);
					state_q <= (count_q == 16'(clr_take)) ? S_SK_CHK : S_CL_RD;
				end
				S_SK_CHK: begin
					if (hint_q < wiu_q) begin
						state_q <= S_SK_TST;
					end else if (!wrap_q) begin
						wrap_q <= 1'b1;
						hint_q <= '0;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SK_TST: begin
					if (ram_rdata == '0) begin
						hint_q  <= hint_q + HW'(1);
						state_q <= S_SK_CHK;
					end else if (!wrap_q) begin
						// hint already on a live word: the second pass changes nothing
						state_q <= S_FIN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FR_CHK: begin
					if (count_q == '0) begin
						state_q <= S_FIN;
					end else if (32'(cur_word) >= 32'(MAP_WORDS)) begin
						status_q <= ST_RANGE;
						state_q  <= S_FIN;
					end else if (HW'(cur_word) >= wiu_q) begin
						wiu_q <= wiu_q + HW'(1);
					end else begin
						state_q <= S_FR_TST;
					end
				end
				S_FR_TST: begin
					if (|(ram_rdata & cur_onehot)) begin
						status_q <= ST_NOTALLOC;
						state_q  <= S_FIN;
					end else begin
						if (HW'(cur_word) < hint_q) begin
							hint_q <= HW'(cur_word);
						end
						frame_q <= frame_q + FW'(1);
						count_q <= count_q - 16'd1;
						state_q <= S_FR_CHK;
					end
				end
				S_Q_TST: begin
					alloc_q <= !(|(ram_rdata & cur_onehot));
					state_q <= S_FIN;
				end
				S_RS_WR: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					// hold the result until the output register is free; base only on success
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {1'b0, 11'(wiu_q), alloc_q,
							(status_q == ST_OK) ? 32'(32'(start_q) << FSH) : 32'd0,
							status_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	bfa_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (BITS_PER_WORD)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ----- rtl/bfa_checker.sv -----
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg.
module bfa_checker
	import bfa_pkg::*;
#(
	parameter int MAP_WORDS = BFA_MAP_WORDS
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [BFA_IN_DATA_W-1:0]  s_tdata,
	input logic [1:0]                s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [BFA_OUT_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_base_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:3] != 32'd0 |-> m_tdata[2:0] == ST_OK)
		else $error("base address given with failing status");

	a_alloc_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35] |-> m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_RANGE)
		else $error("allocated flag with wrong status");

	a_words: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[46:36]) <= 32'(MAP_WORDS) || MAP_WORDS > 2047)
		else $error("words in use beyond map size");

endmodule

bind bitmap_frame_allocator bfa_checker #(.MAP_WORDS(MAP_WORDS)) u_bfa_checker (.*);
